/* rtl/ucts_pkg.sv */
// Shared types and constants of the USB control-transfer sequencer.
// No dependencies; every other file of the block but ucts_if imports this package.
package ucts_pkg;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_START_READ  = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_TOKEN_DONE  = 2'd2
  } op_e;

  // Handshake codes with a meaning of their own; every other non-zero code is an error
  localparam logic [3:0] HS_ACK     = 4'd0;
  localparam logic [3:0] HS_NAK     = 4'd4;
  localparam logic [3:0] HS_TIMEOUT = 4'd14;

  // Token kinds
  typedef enum logic [1:0] {
    TK_SETUP      = 2'd0,
    TK_IN_DATA    = 2'd1,
    TK_OUT_STATUS = 2'd2,
    TK_IN_STATUS  = 2'd3
  } token_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_PACKET  = 2'd0;
  localparam logic [1:0] CFG_NAK_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

  // Configuration reset values
  localparam logic [6:0]  MaxPacketReset  = 7'd8;
  localparam logic [15:0] NakLimitReset   = 16'd200;
  localparam logic [3:0]  RetryLimitReset = 4'd3;

  typedef struct packed {
    logic [6:0]  max_packet_size;
    logic [15:0] naks_allowed;
    logic [3:0]  timeouts_allowed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_length;
    logic [3:0]  endpoint_number;
    logic [3:0]  handshake_code;
    logic [6:0]  received_count;
  } item_t;

  typedef struct packed {
    logic        launch;
    logic [1:0]  token_kind;
    logic [3:0]  endpoint_out;
    logic        force_data1;
    logic [16:0] store_offset;
    logic        store_valid;
    logic        done_res;
    logic [3:0]  status;
    logic [16:0] bytes_received;
    logic [15:0] data_stage_naks;
  } res_t;

endpackage

/* rtl/ucts_if.sv */
// Channel interfaces of the USB control-transfer sequencer: request, result, configuration.
// Plain valid/ready channels; no package dependency.
interface ucts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] request_length;
  logic [3:0]  endpoint_number;
  logic [3:0]  handshake_code;
  logic [6:0]  received_count;

  modport source (output valid, opcode, request_length, endpoint_number, handshake_code,
                  received_count, input ready);
  modport sink (input valid, opcode, request_length, endpoint_number, handshake_code,
                received_count, output ready);
endinterface

interface ucts_out_if;
  logic        valid;
  logic        ready;
  logic        launch;
  logic [1:0]  token_kind;
  logic [3:0]  endpoint_out;
  logic        force_data1;
  logic [16:0] store_offset;
  logic        store_valid;
  logic        done_res;
  logic [3:0]  status;
  logic [16:0] bytes_received;
  logic [15:0] data_stage_naks;

  modport source (output valid, launch, token_kind, endpoint_out, force_data1, store_offset,
                  store_valid, done_res, status, bytes_received, data_stage_naks,
                  input ready);
  modport sink (input valid, launch, token_kind, endpoint_out, force_data1, store_offset,
                store_valid, done_res, status, bytes_received, data_stage_naks,
                output ready);
endinterface

interface ucts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/ucts_cfg_regs.sv */
// Configuration registers of the USB control-transfer sequencer.
// Depends on ucts_pkg (cfg_t, register indexes, reset values).
module ucts_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  logic [1:0]      wr_addr_i,
  input  logic [15:0]     wr_data_i,
  output ucts_pkg::cfg_t  cfg_o
);
  import ucts_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_packet_size  <= MaxPacketReset;
      cfg_q.naks_allowed     <= NakLimitReset;
      cfg_q.timeouts_allowed <= RetryLimitReset;
    end else if (wr_valid_i) begin
      case (wr_addr_i)
        CFG_MAX_PACKET:  cfg_q.max_packet_size  <= wr_data_i[6:0];
        CFG_NAK_LIMIT:   cfg_q.naks_allowed     <= wr_data_i;
        CFG_RETRY_LIMIT: cfg_q.timeouts_allowed <= wr_data_i[3:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/ucts_core.sv */
// Transfer state and next-token decision of the USB control-transfer sequencer.
// Depends on ucts_pkg (item_t, res_t, cfg_t, codes).
module ucts_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  ucts_pkg::item_t item_i,
  input  ucts_pkg::cfg_t  cfg_i,
  output logic            res_valid_o,
  output ucts_pkg::res_t  res_o
);
  import ucts_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'b00001,
    PH_SETUP      = 5'b00010,
    PH_DATA       = 5'b00100,
    PH_STATUS_OUT = 5'b01000,
    PH_STATUS_IN  = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        is_read_q, is_read_d;
  logic [3:0]  ep_q, ep_d;
  logic [15:0] nak_q, nak_d;
  logic [3:0]  tmo_q, tmo_d;
  logic [15:0] wanted_q, wanted_d;
  logic [16:0] total_q, total_d;
  logic [15:0] saved_naks_q, saved_naks_d;

  logic [15:0] nak_inc;
  logic [3:0]  tmo_inc;
  logic [16:0] total_sum;
  logic        is_start, is_done_tok, fail, last_pkt;
  token_e      retry_kind;

  assign nak_inc     = nak_q + 16'd1;
  assign tmo_inc     = tmo_q + 4'd1;
  assign total_sum   = total_q + {10'd0, item_i.received_count};
  assign is_start    = (item_i.opcode == OP_START_READ) || (item_i.opcode == OP_START_WRITE);
  assign is_done_tok = (item_i.opcode == OP_TOKEN_DONE) && (phase_q != PH_IDLE);
  assign last_pkt    = (item_i.received_count < cfg_i.max_packet_size)
                    || (total_sum >= {1'b0, wanted_q});

  always_comb begin
    case (phase_q)
      PH_DATA:       retry_kind = TK_IN_DATA;
      PH_STATUS_OUT: retry_kind = TK_OUT_STATUS;
      PH_STATUS_IN:  retry_kind = TK_IN_STATUS;
      default:       retry_kind = TK_SETUP;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    is_read_d    = is_read_q;
    ep_d         = ep_q;
    nak_d        = nak_q;
    tmo_d        = tmo_q;
    wanted_d     = wanted_q;
    total_d      = total_q;
    saved_naks_d = saved_naks_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    fail         = 1'b0;

    if (is_start && (phase_q == PH_IDLE)) begin
      is_read_d         = (item_i.opcode == OP_START_READ);
      ep_d              = item_i.endpoint_number;
      wanted_d          = (item_i.opcode == OP_START_READ) ? item_i.request_length : 16'd0;
      total_d           = '0;
      saved_naks_d      = '0;
      nak_d             = '0;
      tmo_d             = '0;
      phase_d           = PH_SETUP;
      res_valid_o       = 1'b1;
      res_o.launch      = 1'b1;
      res_o.token_kind  = TK_SETUP;
      res_o.endpoint_out = item_i.endpoint_number;
    end else if (is_done_tok) begin
      res_valid_o = 1'b1;
      if (item_i.handshake_code == HS_NAK) begin
        nak_d = nak_inc;
        fail  = (nak_inc >= cfg_i.naks_allowed);
      end else if (item_i.handshake_code == HS_TIMEOUT) begin
        tmo_d = tmo_inc;
        fail  = (tmo_inc >= cfg_i.timeouts_allowed);
      end else if (item_i.handshake_code != HS_ACK) begin
        fail = 1'b1;
      end

      if (fail) begin
        // give up: report the code and the counts so far
        if (phase_q == PH_DATA) saved_naks_d = nak_d;
        phase_d               = PH_IDLE;
        res_o.done_res        = 1'b1;
        res_o.status          = item_i.handshake_code;
        res_o.bytes_received  = total_q;
        res_o.data_stage_naks = saved_naks_d;
      end else if (item_i.handshake_code != HS_ACK) begin
        // relaunch the same token, keep the counters
        res_o.launch       = 1'b1;
        res_o.token_kind   = retry_kind;
        res_o.endpoint_out = ep_q;
      end else begin
        case (phase_q)
          PH_SETUP: begin
            nak_d              = '0;
            tmo_d              = '0;
            res_o.launch       = 1'b1;
            res_o.endpoint_out = ep_q;
            if (is_read_q) begin
              phase_d           = PH_DATA;
              res_o.token_kind  = TK_IN_DATA;
              res_o.force_data1 = 1'b1;
            end else begin
              phase_d          = PH_STATUS_IN;
              res_o.token_kind = TK_IN_STATUS;
            end
          end
          PH_DATA: begin
            nak_d              = '0;
            tmo_d              = '0;
            total_d            = total_sum;
            res_o.launch       = 1'b1;
            res_o.endpoint_out = ep_q;
            res_o.store_offset = total_q;
            res_o.store_valid  = 1'b1;
            if (last_pkt) begin
              saved_naks_d     = nak_q;
              phase_d          = PH_STATUS_OUT;
              res_o.token_kind = TK_OUT_STATUS;
            end else begin
              res_o.token_kind = TK_IN_DATA;
            end
          end
          default: begin
            // status stage acknowledged: transfer complete
            phase_d               = PH_IDLE;
            res_o.done_res        = 1'b1;
            res_o.status          = HS_ACK;
            res_o.bytes_received  = total_q;
            res_o.data_stage_naks = saved_naks_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      is_read_q    <= 1'b0;
      ep_q         <= '0;
      nak_q        <= '0;
      tmo_q        <= '0;
      wanted_q     <= '0;
      total_q      <= '0;
      saved_naks_q <= '0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      is_read_q    <= is_read_d;
      ep_q         <= ep_d;
      nak_q        <= nak_d;
      tmo_q        <= tmo_d;
      wanted_q     <= wanted_d;
      total_q      <= total_d;
      saved_naks_q <= saved_naks_d;
    end
  end

endmodule

/* rtl/usb_control_transfer_sequencer.sv */
// Top level of the USB control-transfer sequencer: request register, core, result register.
// Depends on ucts_pkg, ucts_if, ucts_cfg_regs and ucts_core.

// USB host control-transfer sequencer. Send a start-read or start-write request to begin a
// transfer, then one token-finished request per completed bus token; each request yields at
// most one result that names the next token to launch (SETUP, IN data, OUT status, IN status)
// or reports the end of the transfer with status, byte total and data-stage NAK count. NAKs
// and timeouts are retried up to the NAK limit and the timeout limit registers; any other
// error ends the transfer. Requests that arrive in the wrong phase are dropped without a
// result. Rate: one request per cycle while results are taken; a request is held in the
// request register and its result is loaded from there into the result register, which
// offers it on the output. A stalled result holds the request register, which in turn holds
// the input. The throughput is set by the state update of the core, which feeds back on
// itself.
// Write the configuration registers only while no transfer is in flight.
module usb_control_transfer_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  ucts_in_if.sink       in_i,
  ucts_out_if.source    out_o,
  ucts_cfg_if.sink      cfg_i
);
  import ucts_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid_q;
  logic  advance;
  logic  out_free;
  logic  core_res_valid;
  res_t  core_res;
  res_t  res_q;
  logic  res_valid_q;

  // Configuration port: always ready
  assign cfg_i.ready = 1'b1;

  ucts_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_addr_i  (cfg_i.addr),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Advance the held request once the result register can take whatever it yields
  assign out_free   = !res_valid_q || out_o.ready;
  assign advance    = item_valid_q && out_free;
  assign in_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  // Request payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode          <= in_i.opcode;
      item_q.request_length  <= in_i.request_length;
      item_q.endpoint_number <= in_i.endpoint_number;
      item_q.handshake_code  <= in_i.handshake_code;
      item_q.received_count  <= in_i.received_count;
    end
  end

  ucts_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (item_q),
    .cfg_i       (cfg),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  // Result register: load a fresh result, otherwise drop the one just taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && core_res_valid) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && core_res_valid) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid           = res_valid_q;
  assign out_o.launch          = res_q.launch;
  assign out_o.token_kind      = res_q.token_kind;
  assign out_o.endpoint_out    = res_q.endpoint_out;
  assign out_o.force_data1     = res_q.force_data1;
  assign out_o.store_offset    = res_q.store_offset;
  assign out_o.store_valid     = res_q.store_valid;
  assign out_o.done_res        = res_q.done_res;
  assign out_o.status          = res_q.status;
  assign out_o.bytes_received  = res_q.bytes_received;
  assign out_o.data_stage_naks = res_q.data_stage_naks;

  // A result either launches a token or ends the transfer, never both
  a_launch_xor_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.launch != res_q.done_res))
    else $error("result both launches and ends the transfer");

  // Stored packet bytes always come with the next token of the same transfer
  a_store_with_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.store_valid) |-> res_q.launch)
    else $error("store without a launched token");

  // DATA1 is forced only for an IN data token
  a_force_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.force_data1) |-> (res_q.token_kind == TK_IN_DATA))
    else $error("DATA1 forced on a token other than IN data");

  // A stalled result is held, never overwritten
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_o.ready) |=> (res_valid_q && $stable(res_q)))
    else $error("pending result lost or changed");

  // A held request is never lost while the result side is blocked
  a_request_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && !advance) |=> item_valid_q)
    else $error("held request dropped");

endmodule
